// ----- rtl/core/tbpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Tape block pulse encoder package
// Shared types and constants for the tape image to pulse train encoder.
// ----------------------------------------------------------------------------
package tbpe_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [21:0] pulse_len;
    logic [15:0] repeat_count;
    logic        block_end;
    logic        truncated;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [15:0] pilot_pulse_len;
    logic [15:0] sync_first_len;
    logic [15:0] sync_second_len;
    logic [15:0] zero_bit_len;
    logic [15:0] one_bit_len;
    logic [15:0] header_pilot_count;
    logic [15:0] data_pilot_count;
    logic [11:0] ms_pause_len;
  } cfg_t;

  // Work for the back end, as decided by the front end for one input byte.
  typedef struct packed {
    logic       lead;
    logic       bits;
    logic       pause;
    logic       trunc;
    logic [7:0] data_byte;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_LEN_LO,
    PH_LEN_HI,
    PH_FLAG,
    PH_DATA
  } phase_e;

  typedef enum logic [2:0] {
    ST_PILOT,
    ST_SYNC1,
    ST_SYNC2,
    ST_BITS,
    ST_PAUSE_LONG,
    ST_PAUSE_SHORT,
    ST_TRUNC
  } step_e;

  localparam logic [2:0] CFG_PILOT_LEN     = 3'd0;
  localparam logic [2:0] CFG_SYNC_FIRST    = 3'd1;
  localparam logic [2:0] CFG_SYNC_SECOND   = 3'd2;
  localparam logic [2:0] CFG_ZERO_LEN      = 3'd3;
  localparam logic [2:0] CFG_ONE_LEN       = 3'd4;
  localparam logic [2:0] CFG_HEADER_PILOTS = 3'd5;
  localparam logic [2:0] CFG_DATA_PILOTS   = 3'd6;
  localparam logic [2:0] CFG_MS_PAUSE      = 3'd7;

  localparam cfg_t CFG_RESET = '{
    pilot_pulse_len:    16'd2168,
    sync_first_len:     16'd667,
    sync_second_len:    16'd735,
    zero_bit_len:       16'd855,
    one_bit_len:        16'd1710,
    header_pilot_count: 16'd8064,
    data_pilot_count:   16'd3224,
    ms_pause_len:       12'd3500
  };

  localparam logic [9:0]  PAUSE_MS_COUNT = 10'd999;
  localparam logic [15:0] BIT_REPEAT     = 16'd2;
  localparam logic [2:0]  LAST_BIT       = 3'd7;

endpackage

// ----- rtl/core/tbpe_front.sv -----
// ----------------------------------------------------------------------------
// Tape block pulse encoder front end
// Parses block lengths and flag bytes and turns each byte into a command.
// ----------------------------------------------------------------------------
module tbpe_front import tbpe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_stall_o,
  input  logic     full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] remain_q, remain_d;
  logic [15:0] total;
  logic [15:0] rem_dec;
  logic        accept;
  logic        open;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;
  assign total      = {in_data_i.data_byte, len_lo_q};
  assign rem_dec    = remain_q - 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEN_LO;
      len_lo_q <= '0;
      remain_q <= '0;
    end else begin
      phase_q  <= phase_d;
      len_lo_q <= len_lo_d;
      remain_q <= remain_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    len_lo_d = len_lo_q;
    remain_d = remain_q;
    cmd_o    = '0;
    open     = 1'b1;
    cmd_o.data_byte = in_data_i.data_byte;
    case (phase_q)
      PH_LEN_LO: begin
        len_lo_d = in_data_i.data_byte;
        phase_d  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (total == '0) begin
          cmd_o.lead      = 1'b1;
          cmd_o.pause     = 1'b1;
          cmd_o.data_byte = '0;
          phase_d         = PH_LEN_LO;
          open            = 1'b0;
        end else begin
          remain_d = total;
          phase_d  = PH_FLAG;
        end
      end
      PH_FLAG, PH_DATA: begin
        cmd_o.lead = (phase_q == PH_FLAG);
        cmd_o.bits = 1'b1;
        remain_d   = rem_dec;
        if (rem_dec == '0) begin
          cmd_o.pause = 1'b1;
          phase_d     = PH_LEN_LO;
          open        = 1'b0;
        end else begin
          phase_d = PH_DATA;
        end
      end
      default: begin
        phase_d = PH_LEN_LO;
      end
    endcase
    if (in_data_i.end_of_file && open) begin
      cmd_o.trunc = 1'b1;
      phase_d     = PH_LEN_LO;
      len_lo_d    = '0;
      remain_d    = '0;
    end
    if (!accept) begin
      phase_d  = phase_q;
      len_lo_d = len_lo_q;
      remain_d = remain_q;
    end
  end

  assign push_o = accept & (cmd_o.lead | cmd_o.bits | cmd_o.pause | cmd_o.trunc);

endmodule

// ----- rtl/core/tbpe_fifo.sv -----
// ----------------------------------------------------------------------------
// Tape block pulse encoder command queue
// A short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tbpe_fifo import tbpe_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] res;
    if (ptr == PtrW'(Depth - 1)) begin
      res = '0;
    end else begin
      res = ptr + PtrW'(1);
    end
    return res;
  endfunction

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/tbpe_back.sv -----
// ----------------------------------------------------------------------------
// Tape block pulse encoder back end
// Steps through each command and emits one pulse item per cycle unless stalled.
// ----------------------------------------------------------------------------
module tbpe_back import tbpe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      head_valid_i,
  input  cmd_t      head_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  step_e     step_q, step_d;
  step_e     cur_step;
  step_e     next_step;
  logic      first_q, first_d;
  logic [2:0] bit_q, bit_d;
  logic [2:0] cur_bit;
  logic      last;
  logic      out_free;
  logic      emit;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  out_item_t item;
  logic [21:0] pause_long;

  function automatic step_e after_bits(input cmd_t c, output logic done);
    step_e s;
    done = 1'b0;
    s    = ST_TRUNC;
    if (c.pause) begin
      s = ST_PAUSE_LONG;
    end else if (!c.trunc) begin
      done = 1'b1;
    end
    return s;
  endfunction

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign emit       = head_valid_i & out_free;
  assign pause_long = 22'(cfg_i.ms_pause_len) * 22'(PAUSE_MS_COUNT);
  assign cur_bit    = first_q ? 3'd0 : bit_q;

  always_comb begin
    if (!first_q) begin
      cur_step = step_q;
    end else if (head_data_i.lead) begin
      cur_step = ST_PILOT;
    end else if (head_data_i.bits) begin
      cur_step = ST_BITS;
    end else if (head_data_i.pause) begin
      cur_step = ST_PAUSE_LONG;
    end else begin
      cur_step = ST_TRUNC;
    end
  end

  always_comb begin
    item      = '0;
    next_step = ST_TRUNC;
    last      = 1'b0;
    bit_d     = bit_q;
    case (cur_step)
      ST_PILOT: begin
        item.pulse_len    = 22'(cfg_i.pilot_pulse_len);
        item.repeat_count = head_data_i.data_byte[7] ? cfg_i.data_pilot_count
                                                     : cfg_i.header_pilot_count;
        next_step = ST_SYNC1;
      end
      ST_SYNC1: begin
        item.pulse_len    = 22'(cfg_i.sync_first_len);
        item.repeat_count = 16'd1;
        next_step = ST_SYNC2;
      end
      ST_SYNC2: begin
        item.pulse_len    = 22'(cfg_i.sync_second_len);
        item.repeat_count = 16'd1;
        if (head_data_i.bits) begin
          next_step = ST_BITS;
          bit_d     = '0;
        end else begin
          next_step = after_bits(head_data_i, last);
        end
      end
      ST_BITS: begin
        item.pulse_len    = head_data_i.data_byte[LAST_BIT - cur_bit]
                            ? 22'(cfg_i.one_bit_len) : 22'(cfg_i.zero_bit_len);
        item.repeat_count = BIT_REPEAT;
        if (cur_bit != LAST_BIT) begin
          next_step = ST_BITS;
          bit_d     = cur_bit + 3'd1;
        end else begin
          next_step = after_bits(head_data_i, last);
        end
      end
      ST_PAUSE_LONG: begin
        item.pulse_len    = pause_long;
        item.repeat_count = 16'd1;
        next_step = ST_PAUSE_SHORT;
      end
      ST_PAUSE_SHORT: begin
        item.pulse_len    = 22'(cfg_i.ms_pause_len);
        item.repeat_count = 16'd1;
        item.block_end    = 1'b1;
        if (head_data_i.trunc) begin
          next_step = ST_TRUNC;
        end else begin
          last = 1'b1;
        end
      end
      ST_TRUNC: begin
        item.truncated = 1'b1;
        last = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
    item.last_of_run = last;
  end

  always_comb begin
    step_d      = step_q;
    first_d     = first_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = emit;
      if (emit) begin
        out_d = item;
      end
    end
    if (emit) begin
      step_d  = next_step;
      first_d = last;
    end
  end

  assign pop_o = emit & last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_PILOT;
      first_q     <= 1'b1;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      first_q     <= first_d;
      bit_q       <= emit ? bit_d : bit_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/tape_block_pulse_encoder.sv -----
// ----------------------------------------------------------------------------
// Tape block pulse encoder
// Turns the bytes of a tape image into the pulse train of a tape loader.
// ----------------------------------------------------------------------------
// Bytes of the image enter on the input channel, one per transaction, with an
// end-of-file bit on the last one. Each result transaction carries one pulse
// length with a repeat count, plus block-end, truncation and last-of-run bits.
// The configuration channel writes the eight timing registers by index and is
// always ready; write it only while no work is in flight.
// Length bytes produce no result, save a truncation mark at end of file and
// the lead-in and block-end pause of a zero length. A data byte produces
// eight results, the flag byte eleven, and a block end two more. The back end
// emits one result per cycle unless the receiver stalls, which sets the rate.
// The front end keeps accepting bytes into a short command queue while the back
// end works; input stall rises only when that queue is full.
// When the receiver stalls, the output register holds its result and the back
// end waits; the queue then fills and stalls the input.
// Reset returns the parser to the start of a block, empties the queue and loads
// the default timing registers.
// ----------------------------------------------------------------------------
module tape_block_pulse_encoder import tbpe_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PILOT_LEN:     cfg_d.pilot_pulse_len    = cfg_data_i;
        CFG_SYNC_FIRST:    cfg_d.sync_first_len     = cfg_data_i;
        CFG_SYNC_SECOND:   cfg_d.sync_second_len    = cfg_data_i;
        CFG_ZERO_LEN:      cfg_d.zero_bit_len       = cfg_data_i;
        CFG_ONE_LEN:       cfg_d.one_bit_len        = cfg_data_i;
        CFG_HEADER_PILOTS: cfg_d.header_pilot_count = cfg_data_i;
        CFG_DATA_PILOTS:   cfg_d.data_pilot_count   = cfg_data_i;
        CFG_MS_PAUSE:      cfg_d.ms_pause_len       = cfg_data_i[11:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tbpe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  tbpe_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_cmd)
  );

  tbpe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_data_i  (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ----- rtl/core/tbpe_checker.sv -----
// ----------------------------------------------------------------------------
// Tape block pulse encoder checker
// Port-level properties of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module tbpe_checker import tbpe_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_item_t   out_data_o
);

  // A stalled result transaction keeps its valid and payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The block-end pause always closes the run of results of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.block_end |-> out_data_o.last_of_run)
    else $error("block-end pause did not close its run");

  // A truncation mark is always the last result and carries no pulse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.truncated |->
      out_data_o.last_of_run && out_data_o.pulse_len == '0 &&
      out_data_o.repeat_count == '0 && !out_data_o.block_end)
    else $error("malformed truncation result");

  // The block-end pause is a single pulse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.block_end |-> out_data_o.repeat_count == 16'd1)
    else $error("block-end pause repeated");

endmodule

bind tape_block_pulse_encoder tbpe_checker u_checker (.*);

// ----- tb/sv/tape_block_pulse_encoder_tb.sv -----
// ----------------------------------------------------------------------------
// Tape block pulse encoder testbench
// Feeds tape image bytes through the encoder and checks every pulse result
// against a cycle-free model of the block parser. A short table of directed
// bytes comes first, followed by random well-formed and broken blocks under
// several timing settings, idle patterns and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tape_block_pulse_encoder_tb;
  import tbpe_pkg::*;

  typedef struct packed {
    in_item_t  item;
    logic      has_exp;
    out_item_t exp_first;
  } tape_byte_t;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PAUSE_MS = 999;

  localparam out_item_t NONE = '0;
  localparam out_item_t HDR_PILOT = '{22'd2168, 16'd8064, 1'b0, 1'b0, 1'b0};
  localparam out_item_t DATA_PILOT = '{22'd2168, 16'd3224, 1'b0, 1'b0, 1'b0};
  localparam out_item_t TRUNC_ONLY = '{22'd0, 16'd0, 1'b0, 1'b1, 1'b1};

  localparam cfg_t TIMING_MAX = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 16'hFFFF, 12'hFFF};
  localparam cfg_t TIMING_MIN = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                  16'h0001, 16'h0001, 12'h000};

  localparam tape_byte_t DIRECTED [25] = '{
    // Zero-length block.
    '{'{8'h00, 1'b0}, 1'b0, NONE},
    '{'{8'h00, 1'b0}, 1'b1, HDR_PILOT},
    // Two-byte header block, all-zero flag then an all-ones byte.
    '{'{8'h02, 1'b0}, 1'b0, NONE},
    '{'{8'h00, 1'b0}, 1'b0, NONE},
    '{'{8'h00, 1'b0}, 1'b1, HDR_PILOT},
    '{'{8'hFF, 1'b0}, 1'b0, NONE},
    // One-byte data block.
    '{'{8'h01, 1'b0}, 1'b0, NONE},
    '{'{8'h00, 1'b0}, 1'b0, NONE},
    '{'{8'hFF, 1'b0}, 1'b1, DATA_PILOT},
    // End of image on the last byte of a complete block.
    '{'{8'h03, 1'b0}, 1'b0, NONE},
    '{'{8'h00, 1'b0}, 1'b0, NONE},
    '{'{8'h80, 1'b0}, 1'b1, DATA_PILOT},
    '{'{8'h55, 1'b0}, 1'b0, NONE},
    '{'{8'hAA, 1'b1}, 1'b0, NONE},
    // Image ends on a lone length byte.
    '{'{8'h07, 1'b1}, 1'b1, TRUNC_ONLY},
    // Image ends right after the length.
    '{'{8'h05, 1'b0}, 1'b0, NONE},
    '{'{8'h00, 1'b1}, 1'b1, TRUNC_ONLY},
    // Image ends inside the data.
    '{'{8'h04, 1'b0}, 1'b0, NONE},
    '{'{8'h00, 1'b0}, 1'b0, NONE},
    '{'{8'h12, 1'b0}, 1'b0, NONE},
    '{'{8'h34, 1'b1}, 1'b0, NONE},
    // Largest length, cut short after the flag and one byte.
    '{'{8'hFF, 1'b0}, 1'b0, NONE},
    '{'{8'hFF, 1'b0}, 1'b0, NONE},
    '{'{8'h7F, 1'b0}, 1'b1, HDR_PILOT},
    '{'{8'hC3, 1'b1}, 1'b0, NONE}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  cfg_t        timing = CFG_RESET;
  phase_e      parse_phase = PH_LEN_LO;
  logic [7:0]  length_low = '0;
  logic [15:0] bytes_left = '0;

  tape_byte_t  tape_bytes [$];
  tape_byte_t  offered_byte;
  out_item_t   byte_pulses [$];
  out_item_t   pulses_due [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;

  tape_block_pulse_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void emit_pulse(logic [21:0] len, logic [15:0] rep, logic blk_end,
                                     logic trunc);
    out_item_t r;
    r.pulse_len = len;
    r.repeat_count = rep;
    r.block_end = blk_end;
    r.truncated = trunc;
    r.last_of_run = 1'b0;
    byte_pulses = {byte_pulses, r};
  endfunction

  function automatic void emit_lead_in(logic [7:0] flag);
    emit_pulse(22'(timing.pilot_pulse_len),
               flag[7] ? timing.data_pilot_count : timing.header_pilot_count, 1'b0, 1'b0);
    emit_pulse(22'(timing.sync_first_len), 16'd1, 1'b0, 1'b0);
    emit_pulse(22'(timing.sync_second_len), 16'd1, 1'b0, 1'b0);
  endfunction

  function automatic void emit_pause();
    emit_pulse(22'(PAUSE_MS * timing.ms_pause_len), 16'd1, 1'b0, 1'b0);
    emit_pulse(22'(timing.ms_pause_len), 16'd1, 1'b1, 1'b0);
  endfunction

  function automatic void encode_tape_byte(in_item_t it);
    logic      block_open;
    out_item_t r;
    block_open = 1'b1;
    byte_pulses.delete();
    case (parse_phase)
      PH_LEN_LO: begin
        length_low = it.data_byte;
        parse_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        bytes_left = {it.data_byte, length_low};
        if (bytes_left == 16'd0) begin
          emit_lead_in(8'h00);
          emit_pause();
          parse_phase = PH_LEN_LO;
          block_open = 1'b0;
        end else begin
          parse_phase = PH_FLAG;
        end
      end
      default: begin
        if (parse_phase == PH_FLAG) emit_lead_in(it.data_byte);
        for (int b = 7; b >= 0; b--) begin
          emit_pulse(it.data_byte[b] ? 22'(timing.one_bit_len) : 22'(timing.zero_bit_len),
                     16'd2, 1'b0, 1'b0);
        end
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) begin
          emit_pause();
          parse_phase = PH_LEN_LO;
          block_open = 1'b0;
        end else begin
          parse_phase = PH_DATA;
        end
      end
    endcase
    if (it.end_of_file && block_open) begin
      emit_pulse(22'd0, 16'd0, 1'b0, 1'b1);
      parse_phase = PH_LEN_LO;
      length_low = '0;
      bytes_left = '0;
    end
    if (byte_pulses.size() != 0) begin
      r = byte_pulses.pop_back();
      r.last_of_run = 1'b1;
      byte_pulses = {byte_pulses, r};
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Sender: offers bytes, and predicts each one at the edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        encode_tape_byte(offered_byte.item);
        if (offered_byte.has_exp &&
            (byte_pulses.size() == 0 || byte_pulses[0] !== offered_byte.exp_first)) begin
          $display("%0t: first pulse expected %h, actual %h", $time, offered_byte.exp_first,
                   (byte_pulses.size() == 0) ? NONE : byte_pulses[0]);
          fail_count++;
        end
        pulses_due = {pulses_due, byte_pulses};
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tape_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_byte = tape_bytes.pop_front();
          in_valid_i <= 1'b1;
          in_data_i <= offered_byte.item;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req <= 1'b0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pulses_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
        fail_count++;
      end else begin
        want = pulses_due.pop_front();
        check_field("pulse_len", want.pulse_len, out_data_o.pulse_len);
        check_field("repeat_count", want.repeat_count, out_data_o.repeat_count);
        check_field("block_end", want.block_end, out_data_o.block_end);
        check_field("truncated", want.truncated, out_data_o.truncated);
        check_field("last_of_run", want.last_of_run, out_data_o.last_of_run);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tape_block_pulse_encoder: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_PILOT_LEN:     timing.pilot_pulse_len = val;
      CFG_SYNC_FIRST:    timing.sync_first_len = val;
      CFG_SYNC_SECOND:   timing.sync_second_len = val;
      CFG_ZERO_LEN:      timing.zero_bit_len = val;
      CFG_ONE_LEN:       timing.one_bit_len = val;
      CFG_HEADER_PILOTS: timing.header_pilot_count = val;
      CFG_DATA_PILOTS:   timing.data_pilot_count = val;
      CFG_MS_PAUSE:      timing.ms_pause_len = val[11:0];
      default: ;
    endcase
  endtask

  task automatic load_timing(cfg_t c);
    write_reg(CFG_PILOT_LEN, c.pilot_pulse_len);
    write_reg(CFG_SYNC_FIRST, c.sync_first_len);
    write_reg(CFG_SYNC_SECOND, c.sync_second_len);
    write_reg(CFG_ZERO_LEN, c.zero_bit_len);
    write_reg(CFG_ONE_LEN, c.one_bit_len);
    write_reg(CFG_HEADER_PILOTS, c.header_pilot_count);
    write_reg(CFG_DATA_PILOTS, c.data_pilot_count);
    write_reg(CFG_MS_PAUSE, {4'($urandom_range(15)), c.ms_pause_len});
  endtask

  function automatic cfg_t random_timing();
    cfg_t c;
    c.pilot_pulse_len = 16'($urandom_range(16'hFFFF));
    c.sync_first_len = 16'($urandom_range(16'hFFFF));
    c.sync_second_len = 16'($urandom_range(16'hFFFF));
    c.zero_bit_len = 16'($urandom_range(16'hFFFF));
    c.one_bit_len = 16'($urandom_range(16'hFFFF));
    c.header_pilot_count = 16'($urandom_range(16'hFFFF, 1));
    c.data_pilot_count = 16'($urandom_range(16'hFFFF, 1));
    c.ms_pause_len = 12'($urandom_range(12'hFFF));
    return c;
  endfunction

  task automatic queue_blocks(int unsigned n_bytes);
    int unsigned made;
    int unsigned kind;
    int unsigned total;
    int unsigned send_n;
    logic [15:0] hdr_len;
    tape_byte_t  s;
    made = 0;
    while (made < n_bytes) begin
      kind = $urandom_range(99);
      if (kind < 8) hdr_len = 16'd0;
      else if (kind < 80) hdr_len = 16'($urandom_range(6, 1));
      else if (kind < 90) hdr_len = 16'($urandom_range(24, 7));
      else hdr_len = 16'($urandom_range(16'hFFFF));
      total = 32'(hdr_len) + 32'd2;
      if (kind >= 90 || $urandom_range(99) < 10) begin
        send_n = $urandom_range((total > 9) ? 9 : total - 1, 1);
      end else begin
        send_n = total;
      end
      for (int unsigned i = 0; i < send_n; i++) begin
        s = '0;
        if (i == 0) s.item.data_byte = hdr_len[7:0];
        else if (i == 1) s.item.data_byte = hdr_len[15:8];
        else s.item.data_byte = 8'($urandom_range(255));
        s.item.end_of_file = (i == send_n - 1) && (send_n < total || $urandom_range(99) < 5);
        tape_bytes = {tape_bytes, s};
      end
      made += send_n;
    end
  endtask

  task automatic drain();
    do @(posedge clk_i); while (tape_bytes.size() != 0 || in_valid_i);
    while (pulses_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned sidle, int unsigned rstall, int unsigned n_bytes,
                           logic long_hold);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    queue_blocks(n_bytes);
    if (long_hold) hold_req <= 1'b1;
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < $size(DIRECTED); i++) tape_bytes = {tape_bytes, DIRECTED[i]};
    drain();

    load_timing(random_timing());
    run_phase(74, 0, 100, 1'b0);
    load_timing(TIMING_MAX);
    run_phase(0, 74, 100, 1'b1);
    load_timing(TIMING_MIN);
    run_phase(11, 11, 90, 1'b0);
    load_timing(random_timing());
    run_phase(0, 0, 50, 1'b0);
    run_phase(0, 0, 40, 1'b0);

    if (fail_count == 0 && pulses_due.size() == 0) begin
      $display("tape_block_pulse_encoder: match");
    end else begin
      $display("tape_block_pulse_encoder: mismatch");
    end
    $finish;
  end

endmodule
